>>> hw/rtl/assert_macros.svh
// Assertion helpers for the RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checks that a property holds at every rising clock edge outside reset.
`define ASSERT_ALWAYS(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Checks that a condition implies a consequence in the same cycle.
`define ASSERT_IMPLIES(label, clk, rst_n, cond, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (cons)) \
    else $error(msg);

`endif

>>> hw/rtl/suvm_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
package suvm_pkg;

  localparam int unsigned CordicSteps = 20;
  localparam int unsigned AngleWidth = 26;
  localparam int unsigned UnitQ16 = 65536;
  localparam int unsigned OutWidth = 17;

  localparam logic signed [AngleWidth-1:0] HalfTurn = 26'sd8388608;
  localparam logic signed [AngleWidth-1:0] QuarterTurn = 26'sd4194304;
  localparam logic [29:0] InvGainQ30 = 30'd652032874;

  typedef struct packed {
    logic degenerate;
    logic on_axis;
  } flags_t;

  function automatic logic signed [AngleWidth-1:0] atan_turn(input int unsigned step);
    logic signed [AngleWidth-1:0] val;
    begin
      case (step)
        0: val = 26'sd2097152;
        1: val = 26'sd1238021;
        2: val = 26'sd654136;
        3: val = 26'sd332050;
        4: val = 26'sd166669;
        5: val = 26'sd83416;
        6: val = 26'sd41718;
        7: val = 26'sd20860;
        8: val = 26'sd10430;
        9: val = 26'sd5215;
        10: val = 26'sd2608;
        11: val = 26'sd1304;
        12: val = 26'sd652;
        13: val = 26'sd326;
        14: val = 26'sd163;
        15: val = 26'sd81;
        16: val = 26'sd41;
        17: val = 26'sd20;
        18: val = 26'sd10;
        19: val = 26'sd5;
        default: val = '0;
      endcase
      return val;
    end
  endfunction

endpackage
`default_nettype wire

>>> hw/rtl/spherical_uv_mapper_unit.sv
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"
// Maps one vertex (x, y, z) per word to spherical texture coordinates u and v, unsigned
// Q1.16, and flags the zero vector. A new vertex is taken every cycle while the output is
// not stalled; each one passes through one input register, 20 CORDIC stages for the
// azimuth, two stages that multiply out the CORDIC gain, 20 CORDIC stages for the polar
// angle and the output register. A stall on the output holds the whole pipeline.
module spherical_uv_mapper_unit #(
  parameter int unsigned COORD_WIDTH = 32
) (
  input  wire logic                                   clk_i,
  input  wire logic                                   rst_ni,
  input  wire logic                                   s_axis_tvalid,
  output logic                                        s_axis_tready,
  // x_coord, y_coord, z_coord
  input  wire logic [((3*COORD_WIDTH+7)/8)*8-1:0]     s_axis_tdata,
  output logic                                        m_axis_tvalid,
  input  wire logic                                   m_axis_tready,
  // u_coord, v_coord
  output logic [39:0]                                 m_axis_tdata,
  // degenerate
  output logic                                        m_axis_tuser
);

  localparam int unsigned W = COORD_WIDTH;
  localparam int unsigned DW = W + 3;
  localparam int unsigned AW = suvm_pkg::AngleWidth;
  localparam int unsigned N = suvm_pkg::CordicSteps;
  localparam int unsigned Side1W = W + 2;
  localparam int unsigned Side2W = AW + 2;

  logic en;
  logic signed [W-1:0] x_in, y_in, z_in;
  logic                in_neg;

  logic                   v0_q;
  logic signed [DW-1:0]   x0_q, z0_q;
  logic signed [AW-1:0]   base0_q;
  logic [Side1W-1:0]      side0_q;

  logic                   v1 [0:N];
  logic signed [DW-1:0]   a1 [0:N];
  logic signed [DW-1:0]   b1 [0:N];
  logic signed [AW-1:0]   c1 [0:N];
  logic [Side1W-1:0]      s1 [0:N];

  logic                   v2 [0:N];
  logic signed [DW-1:0]   a2 [0:N];
  logic signed [DW-1:0]   b2 [0:N];
  logic signed [AW-1:0]   c2 [0:N];
  logic [Side2W-1:0]      s2 [0:N];

  suvm_pkg::flags_t       flags_g, flags_e;
  logic signed [AW-1:0]   phi_g, phi_e, u_t, v_t;
  logic [AW-1:0]          u_r, v_r;
  logic [suvm_pkg::OutWidth-1:0] u_d, v_d, u_q, v_q;
  logic                   vo_q, deg_q;

  assign en = m_axis_tready || !vo_q;
  assign s_axis_tready = en;

  assign x_in = $signed(s_axis_tdata[W-1:0]);
  assign y_in = $signed(s_axis_tdata[2*W-1:W]);
  assign z_in = $signed(s_axis_tdata[3*W-1:2*W]);
  assign in_neg = x_in[W-1];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v0_q <= 1'b0;
    end else if (en) begin
      v0_q <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      x0_q    <= in_neg ? -DW'(x_in) : DW'(x_in);
      z0_q    <= in_neg ? -DW'(z_in) : DW'(z_in);
      base0_q <= !in_neg ? '0 : (z_in[W-1] ? -suvm_pkg::HalfTurn : suvm_pkg::HalfTurn);
      side0_q <= {y_in, (x_in == '0) && (y_in == '0) && (z_in == '0),
                  (x_in == '0) && (z_in == '0)};
    end
  end

  assign v1[0] = v0_q;
  assign a1[0] = x0_q;
  assign b1[0] = z0_q;
  assign c1[0] = base0_q;
  assign s1[0] = side0_q;

  for (genvar k = 0; k < N; k++) begin : g_az
    suvm_cordic_stage #(.DataWidth(DW), .SideWidth(Side1W), .Step(k)) u_stage (
      .clk_i, .rst_ni, .en_i(en),
      .valid_i(v1[k]), .a_i(a1[k]), .b_i(b1[k]), .acc_i(c1[k]), .side_i(s1[k]),
      .valid_o(v1[k+1]), .a_o(a1[k+1]), .b_o(b1[k+1]), .acc_o(c1[k+1]), .side_o(s1[k+1])
    );
  end

  suvm_gain #(.CoordWidth(W)) u_gain (
    .clk_i, .rst_ni, .en_i(en),
    .valid_i(v1[N]),
    .r_i(a1[N]),
    .phi_i(c1[N]),
    .y_i($signed(s1[N][Side1W-1:2])),
    .flags_i(suvm_pkg::flags_t'(s1[N][1:0])),
    .valid_o(v2[0]),
    .a_o(a2[0]),
    .b_o(b2[0]),
    .base_o(c2[0]),
    .phi_o(phi_g),
    .flags_o(flags_g)
  );

  assign s2[0] = {phi_g, flags_g};

  for (genvar k = 0; k < N; k++) begin : g_pol
    suvm_cordic_stage #(.DataWidth(DW), .SideWidth(Side2W), .Step(k)) u_stage (
      .clk_i, .rst_ni, .en_i(en),
      .valid_i(v2[k]), .a_i(a2[k]), .b_i(b2[k]), .acc_i(c2[k]), .side_i(s2[k]),
      .valid_o(v2[k+1]), .a_o(a2[k+1]), .b_o(b2[k+1]), .acc_o(c2[k+1]), .side_o(s2[k+1])
    );
  end

  always_comb begin
    phi_e   = $signed(s2[N][Side2W-1:2]);
    flags_e = suvm_pkg::flags_t'(s2[N][1:0]);
    u_t     = phi_e + suvm_pkg::HalfTurn;
    v_t     = c2[N];
    u_r     = u_t[AW-1] ? '0 : ((AW'(u_t) + AW'(128)) >> 8);
    v_r     = v_t[AW-1] ? '0 : ((AW'(v_t) + AW'(64)) >> 7);
    u_d     = (u_r > AW'(suvm_pkg::UnitQ16)) ? suvm_pkg::OutWidth'(suvm_pkg::UnitQ16)
                                             : u_r[suvm_pkg::OutWidth-1:0];
    v_d     = (v_r > AW'(suvm_pkg::UnitQ16)) ? suvm_pkg::OutWidth'(suvm_pkg::UnitQ16)
                                             : v_r[suvm_pkg::OutWidth-1:0];
    if (flags_e.degenerate) begin
      u_d = suvm_pkg::OutWidth'(suvm_pkg::UnitQ16 / 2);
      v_d = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vo_q <= 1'b0;
    end else if (en) begin
      vo_q <= v2[N];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      u_q   <= u_d;
      v_q   <= v_d;
      deg_q <= flags_e.degenerate;
    end
  end

  assign m_axis_tvalid = vo_q;
  assign m_axis_tdata  = {6'b0, v_q, u_q};
  assign m_axis_tuser  = deg_q;

  `ASSERT_ALWAYS(a_u_range, clk_i, rst_ni, !vo_q || (u_q <= 17'd65536), "u out of range")
  `ASSERT_ALWAYS(a_v_range, clk_i, rst_ni, !vo_q || (v_q <= 17'd65536), "v out of range")
  `ASSERT_IMPLIES(a_degen, clk_i, rst_ni, vo_q && deg_q, (u_q == 17'd32768) && (v_q == '0), "degenerate result wrong")
  `ASSERT_IMPLIES(a_hold, clk_i, rst_ni, vo_q && !m_axis_tready, !s_axis_tready, "input taken during stall")

endmodule
`default_nettype wire

>>> hw/rtl/suvm_cordic_stage.sv
`timescale 1ns / 1ps
`default_nettype none
module suvm_cordic_stage #(
  parameter int unsigned DataWidth = 35,
  parameter int unsigned SideWidth = 2,
  parameter int unsigned Step = 0
) (
  input  wire logic                                   clk_i,
  input  wire logic                                   rst_ni,
  input  wire logic                                   en_i,
  input  wire logic                                   valid_i,
  input  wire logic signed [DataWidth-1:0]            a_i,
  input  wire logic signed [DataWidth-1:0]            b_i,
  input  wire logic signed [suvm_pkg::AngleWidth-1:0] acc_i,
  input  wire logic [SideWidth-1:0]                   side_i,
  output logic                                        valid_o,
  output logic signed [DataWidth-1:0]                 a_o,
  output logic signed [DataWidth-1:0]                 b_o,
  output logic signed [suvm_pkg::AngleWidth-1:0]      acc_o,
  output logic [SideWidth-1:0]                        side_o
);

  logic                                   valid_q;
  logic signed [DataWidth-1:0]            a_d, a_q, b_d, b_q, da, db;
  logic signed [suvm_pkg::AngleWidth-1:0] acc_d, acc_q;
  logic [SideWidth-1:0]                   side_q;

  always_comb begin
    da = b_i >>> Step;
    db = a_i >>> Step;
    if (!b_i[DataWidth-1]) begin
      a_d   = a_i + da;
      b_d   = b_i - db;
      acc_d = acc_i + suvm_pkg::atan_turn(Step);
    end else begin
      a_d   = a_i - da;
      b_d   = b_i + db;
      acc_d = acc_i - suvm_pkg::atan_turn(Step);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (en_i) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      a_q    <= a_d;
      b_q    <= b_d;
      acc_q  <= acc_d;
      side_q <= side_i;
    end
  end

  assign valid_o = valid_q;
  assign a_o     = a_q;
  assign b_o     = b_q;
  assign acc_o   = acc_q;
  assign side_o  = side_q;

endmodule
`default_nettype wire

>>> hw/rtl/suvm_gain.sv
`timescale 1ns / 1ps
`default_nettype none
module suvm_gain #(
  parameter int unsigned CoordWidth = 32
) (
  input  wire logic                                   clk_i,
  input  wire logic                                   rst_ni,
  input  wire logic                                   en_i,
  input  wire logic                                   valid_i,
  input  wire logic signed [CoordWidth+2:0]           r_i,
  input  wire logic signed [suvm_pkg::AngleWidth-1:0] phi_i,
  input  wire logic signed [CoordWidth-1:0]           y_i,
  input  wire suvm_pkg::flags_t                       flags_i,
  output logic                                        valid_o,
  output logic signed [CoordWidth+2:0]                a_o,
  output logic signed [CoordWidth+2:0]                b_o,
  output logic signed [suvm_pkg::AngleWidth-1:0]      base_o,
  output logic signed [suvm_pkg::AngleWidth-1:0]      phi_o,
  output suvm_pkg::flags_t                            flags_o
);

  localparam int unsigned DataWidth = CoordWidth + 3;
  localparam int unsigned HiWidth = DataWidth - 16;
  localparam int unsigned SumWidth = HiWidth + 31;

  logic                                   valid1_q, valid2_q;
  logic [HiWidth+29:0]                    prod_hi_q;
  logic [45:0]                            prod_lo_q;
  logic signed [suvm_pkg::AngleWidth-1:0] phi1_q, phi2_q, base2_q;
  logic signed [CoordWidth-1:0]           y1_q;
  suvm_pkg::flags_t                       flags1_q, flags2_q;
  logic [SumWidth-1:0]                    sum;
  logic signed [DataWidth-1:0]            rr, ys, a2_d, b2_d, a2_q, b2_q;
  logic signed [suvm_pkg::AngleWidth-1:0] base2_d;

  always_comb begin
    sum = SumWidth'(prod_hi_q) + SumWidth'(prod_lo_q[45:16]);
    rr  = $signed(sum[DataWidth+13:14]);
    ys  = DataWidth'(y1_q);
    if (y1_q[CoordWidth-1]) begin
      a2_d    = rr;
      b2_d    = -ys;
      base2_d = suvm_pkg::QuarterTurn;
    end else begin
      a2_d    = ys;
      b2_d    = rr;
      base2_d = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid1_q <= 1'b0;
      valid2_q <= 1'b0;
    end else if (en_i) begin
      valid1_q <= valid_i;
      valid2_q <= valid1_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      prod_hi_q <= r_i[DataWidth-1:16] * suvm_pkg::InvGainQ30;
      prod_lo_q <= r_i[15:0] * suvm_pkg::InvGainQ30;
      phi1_q    <= flags_i.on_axis ? '0 : phi_i;
      y1_q      <= y_i;
      flags1_q  <= flags_i;
      a2_q      <= a2_d;
      b2_q      <= b2_d;
      base2_q   <= base2_d;
      phi2_q    <= phi1_q;
      flags2_q  <= flags1_q;
    end
  end

  assign valid_o = valid2_q;
  assign a_o     = a2_q;
  assign b_o     = b2_q;
  assign base_o  = base2_q;
  assign phi_o   = phi2_q;
  assign flags_o = flags2_q;

endmodule
`default_nettype wire
